>>> sv/nogs_pkg.sv
// ---------------------------------------------------------------------------
// nogs_pkg: shared types and constants
// Geometry, register codes, the config and result formats and the item format of the candidate queue.
// ---------------------------------------------------------------------------
package nogs_pkg;

  localparam int unsigned FrameWidth = 500;
  localparam int unsigned Centre     = FrameWidth / 2;
  localparam int unsigned QueueDepth = 4;

  localparam logic [16:0] DistOnes = 17'h1FFFF;

  // register indexes of the config port
  localparam logic [1:0] RegDriveEnable = 2'd0;
  localparam logic [1:0] RegSteerGain   = 2'd1;
  localparam logic [1:0] RegBaseSpeed   = 2'd2;
  localparam logic [1:0] RegErrorLimit  = 2'd3;

  typedef struct packed {
    logic       drive_enable;
    logic [7:0] steer_gain;
    logic [6:0] base_speed;
    logic [7:0] error_limit;
  } cfg_t;

  // classified centroid, front to back
  typedef struct packed {
    logic [16:0] dx_sq;
    logic [15:0] dy_sq;
    logic [8:0]  point_x;
    logic        is_left;
    logic        point_valid;
    logic        frame_last;
  } cand_t;

  typedef struct packed {
    logic        right_found;
    logic        left_found;
    logic [8:0]  right_x;
    logic [8:0]  left_x;
    logic [15:0] right_speed;
    logic [15:0] left_speed;
    logic [8:0]  steer_error;
  } res_t;

endpackage

>>> sv/nogs_front.sv
// ---------------------------------------------------------------------------
// nogs_front: centroid classifier
// Splits a centroid by side and forms the two squared offsets from the
// robot point.
// ---------------------------------------------------------------------------
module nogs_front (
  input  logic [8:0]     point_x_i,
  input  logic [7:0]     point_y_i,
  input  logic           point_valid_i,
  input  logic           frame_last_i,
  output nogs_pkg::cand_t cand_o
);

  logic signed [9:0]  dx;
  logic signed [9:0]  dy;
  logic signed [19:0] dx_prod;
  logic signed [19:0] dy_prod;

  assign dx = $signed({1'b0, point_x_i}) - $signed(10'(nogs_pkg::Centre));
  assign dy = $signed({2'b0, point_y_i}) - $signed(10'(nogs_pkg::Centre));
  assign dx_prod = dx * dx;
  assign dy_prod = dy * dy;

  always_comb begin
    cand_o.dx_sq       = dx_prod[16:0];
    cand_o.dy_sq       = dy_prod[15:0];
    cand_o.point_x     = point_x_i;
    cand_o.is_left     = ({1'b0, point_x_i} < 10'(nogs_pkg::Centre));
    cand_o.point_valid = point_valid_i;
    cand_o.frame_last  = frame_last_i;
  end

endmodule

>>> sv/nogs_fifo.sv
// ---------------------------------------------------------------------------
// nogs_fifo: candidate queue
// Small flop-based FIFO between the classifier and the tracker.
// ---------------------------------------------------------------------------
module nogs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Lw = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0]    wptr_q, wptr_d;
  logic [Aw-1:0]    rptr_q, rptr_d;
  logic [Lw-1:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == Lw'(Depth));
  assign level_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + Lw'(push_i) - Lw'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/nogs_back.sv
// ---------------------------------------------------------------------------
// nogs_back: nearest-obstacle tracker and steering pipeline
// Running minimum per side, then error, gain product and saturated speeds.
// ---------------------------------------------------------------------------
module nogs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nogs_pkg::cfg_t  cfg_i,
  input  nogs_pkg::cand_t cand_i,
  input  logic            cand_vld_i,
  output logic            cand_pop_o,
  output nogs_pkg::res_t  res_o,
  output logic            res_vld_o,
  input  logic            res_rdy_i
);

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    logic [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic adv;

  // tracker state
  logic [16:0] lbest_q, lbest_d, rbest_q, rbest_d;
  logic [8:0]  lbx_q, lbx_d, rbx_q, rbx_d;
  logic        lseen_q, lseen_d, rseen_q, rseen_d;

  // stage 1: closed frame
  logic       s1_vld_q, s1_vld_d;
  logic [8:0] s1_lx_q, s1_rx_q;
  logic       s1_lf_q, s1_rf_q;

  // stage 2: error and gain product
  logic              s2_vld_q, s2_vld_d;
  logic signed [8:0] s2_err_q;
  logic signed [17:0] s2_corr_q;
  logic              s2_straight_q;
  logic [8:0]        s2_lx_q, s2_rx_q;
  logic              s2_lf_q, s2_rf_q;

  // output register
  logic           out_vld_q, out_vld_d;
  nogs_pkg::res_t out_q;

  logic [17:0] dist_sum;
  logic [16:0] dist_sat;
  logic        pop, l_win, r_win;
  logic [8:0]  fin_lx, fin_rx;

  logic [9:0]         xsum;
  logic signed [9:0]  err10;
  logic signed [8:0]  err;
  logic signed [9:0]  lim;
  logic signed [17:0] corr;
  logic               straight;

  logic signed [18:0] base;
  logic signed [18:0] neg_base;
  logic signed [18:0] corr_w;
  logic signed [18:0] ls_w, rs_w;
  logic [15:0]        ls, rs;

  assign adv        = !out_vld_q || res_rdy_i;
  assign pop        = adv && cand_vld_i;
  assign cand_pop_o = pop;

  // ---- running minimum
  always_comb begin
    dist_sum = {1'b0, cand_i.dx_sq} + {2'b0, cand_i.dy_sq};
    dist_sat = (dist_sum > {1'b0, nogs_pkg::DistOnes}) ? nogs_pkg::DistOnes : dist_sum[16:0];
    l_win    = cand_i.point_valid && cand_i.is_left && (dist_sat < lbest_q);
    r_win    = cand_i.point_valid && !cand_i.is_left && (dist_sat < rbest_q);
    fin_lx   = l_win ? cand_i.point_x : (lseen_q ? lbx_q : '0);
    fin_rx   = r_win ? cand_i.point_x : (rseen_q ? rbx_q : 9'(nogs_pkg::FrameWidth));

    lbest_d = lbest_q;  lbx_d = lbx_q;  lseen_d = lseen_q;
    rbest_d = rbest_q;  rbx_d = rbx_q;  rseen_d = rseen_q;
    if (pop) begin
      if (cand_i.frame_last) begin
        lbest_d = nogs_pkg::DistOnes;  lbx_d = '0;  lseen_d = 1'b0;
        rbest_d = nogs_pkg::DistOnes;  rbx_d = '0;  rseen_d = 1'b0;
      end else begin
        if (l_win) begin
          lbest_d = dist_sat;  lbx_d = cand_i.point_x;  lseen_d = 1'b1;
        end
        if (r_win) begin
          rbest_d = dist_sat;  rbx_d = cand_i.point_x;  rseen_d = 1'b1;
        end
      end
    end
  end

  // ---- error, limit test, gain product
  always_comb begin
    xsum     = {1'b0, s1_lx_q} + {1'b0, s1_rx_q};
    err10    = $signed(10'(nogs_pkg::Centre)) - $signed({1'b0, xsum[9:1]});
    err      = err10[8:0];
    lim      = $signed({2'b0, cfg_i.error_limit});
    straight = (err == '0) || (err10 < -lim) || (err10 > lim);
    corr     = $signed({1'b0, cfg_i.steer_gain}) * err;
  end

  // ---- speeds
  always_comb begin
    base     = $signed({4'b0, cfg_i.base_speed, 8'b0});
    neg_base = -base;
    corr_w   = 19'(s2_corr_q);
    ls_w     = base - corr_w;
    rs_w     = -(base + corr_w);
    if (!cfg_i.drive_enable) begin
      ls = '0;
      rs = '0;
    end else if (s2_straight_q) begin
      ls = base[15:0];
      rs = neg_base[15:0];
    end else begin
      ls = sat16(ls_w);
      rs = sat16(rs_w);
    end
  end

  assign s1_vld_d  = adv ? (pop && cand_i.frame_last) : s1_vld_q;
  assign s2_vld_d  = adv ? s1_vld_q : s2_vld_q;
  assign out_vld_d = adv ? s2_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbest_q   <= nogs_pkg::DistOnes;
      rbest_q   <= nogs_pkg::DistOnes;
      lbx_q     <= '0;
      rbx_q     <= '0;
      lseen_q   <= 1'b0;
      rseen_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      lbest_q   <= lbest_d;
      rbest_q   <= rbest_d;
      lbx_q     <= lbx_d;
      rbx_q     <= rbx_d;
      lseen_q   <= lseen_d;
      rseen_q   <= rseen_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lx_q       <= fin_lx;
      s1_rx_q       <= fin_rx;
      s1_lf_q       <= l_win || lseen_q;
      s1_rf_q       <= r_win || rseen_q;
      s2_err_q      <= err;
      s2_corr_q     <= corr;
      s2_straight_q <= straight;
      s2_lx_q       <= s1_lx_q;
      s2_rx_q       <= s1_rx_q;
      s2_lf_q       <= s1_lf_q;
      s2_rf_q       <= s1_rf_q;
      out_q.steer_error <= s2_err_q;
      out_q.left_speed  <= ls;
      out_q.right_speed <= rs;
      out_q.left_x      <= s2_lx_q;
      out_q.right_x     <= s2_rx_q;
      out_q.left_found  <= s2_lf_q;
      out_q.right_found <= s2_rf_q;
    end
  end

  assign res_o     = out_q;
  assign res_vld_o = out_vld_q;

endmodule

>>> sv/nearest_obstacle_gap_steering.sv
// ---------------------------------------------------------------------------
// nearest_obstacle_gap_steering: gap steering from obstacle centroids
// Picks the nearest obstacle on each side of the robot and turns the gap
// midpoint into a steering error and two wheel speeds.
// ---------------------------------------------------------------------------
// Feed the centroids of one frame as a stream, one item per cycle, tlast on
// the last item and tuser=0 for an empty marker. An item is accepted
// whenever the queue is not full; the classifier squares both offsets on
// entry and parks the candidate in a small queue, and the tracker pops one
// candidate per cycle while the output is not held, so the sustained rate
// is then one item per clock. Only a tlast item produces a result; it
// passes the queue entry, then the tracker pops it into the closed-frame
// register, then error/gain product, then speed saturation into the output
// register. All stages halt only when the downstream holds the output; the
// queue absorbs that stall until it fills, then tready drops. Config writes
// take effect at the next edge and should be made while no frame is in
// flight.
// ---------------------------------------------------------------------------
module nearest_obstacle_gap_steering #(
  parameter int unsigned QUEUE_DEPTH = nogs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // centroid stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [8:0] point_x, [16:9] point_y, rest zero
  input  logic        s_axis_tuser,   // point_valid
  input  logic        s_axis_tlast,   // frame_last
  // steering result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [8:0] steer_error, [24:9] left_speed,
                                     // [40:25] right_speed, [49:41] left_x,
                                     // [58:50] right_x, [59] left_found,
                                     // [60] right_found, rest zero
);

  localparam int unsigned Lw = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CandW = $bits(nogs_pkg::cand_t);

  nogs_pkg::cfg_t  cfg_q, cfg_d;
  nogs_pkg::cand_t cand_in, cand_out;
  nogs_pkg::res_t  res;
  logic [CandW-1:0] q_rdata;
  logic             q_empty, q_full, q_pop, push;
  logic [Lw-1:0]    q_level;

  // config registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nogs_pkg::RegDriveEnable: cfg_d.drive_enable = cfg_wdata_i[0];
        nogs_pkg::RegSteerGain:   cfg_d.steer_gain   = cfg_wdata_i;
        nogs_pkg::RegBaseSpeed:   cfg_d.base_speed   = cfg_wdata_i[6:0];
        nogs_pkg::RegErrorLimit:  cfg_d.error_limit  = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_enable <= 1'b0;
      cfg_q.steer_gain   <= 8'd115;
      cfg_q.base_speed   <= 7'd50;
      cfg_q.error_limit  <= 8'd60;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: classify on entry
  nogs_front u_front (
    .point_x_i     (s_axis_tdata[8:0]),
    .point_y_i     (s_axis_tdata[16:9]),
    .point_valid_i (s_axis_tuser),
    .frame_last_i  (s_axis_tlast),
    .cand_o        (cand_in)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  nogs_fifo #(
    .Width (CandW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cand_in),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full),
    .level_o (q_level)
  );

  assign cand_out = nogs_pkg::cand_t'(q_rdata);

  // back: tracking and steering
  nogs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cand_i     (cand_out),
    .cand_vld_i (!q_empty),
    .cand_pop_o (q_pop),
    .res_o      (res),
    .res_vld_o  (m_axis_tvalid),
    .res_rdy_i  (m_axis_tready)
  );

  assign m_axis_tdata = {3'b0, res};

  // ---- checks
  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= Lw'(QUEUE_DEPTH))
    else $error("candidate queue level out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty candidate queue");

  a_left_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.left_found |-> res.left_x == '0)
    else $error("left x not defaulted without a left obstacle");

  a_right_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.right_found |-> res.right_x == 9'(nogs_pkg::FrameWidth))
    else $error("right x not defaulted without a right obstacle");

endmodule
